/* src/yat_pkg.sv */
// ---------------------------------------------------------------------------
// yat_pkg - shared types and constants for the anchor target assigner
// Controller states, datapath operation codes, handshake structs, and
// configuration register indexes and reset values.
// ---------------------------------------------------------------------------
package yat_pkg;

    localparam int DEF_MAX_ANCHORS = 9;
    localparam int DEF_MAX_MASK    = 4;
    localparam int DEF_MAX_GRID    = 128;

    localparam int Q_W      = 17;              // Q1.16 box and anchor sides
    localparam int PROD_W   = 2 * Q_W;         // Q2.32 product
    localparam int UNI_W    = PROD_W + 2;      // union plus headroom
    localparam int DVD_W    = PROD_W + 16;     // product shifted by 16
    localparam int CLASS_W  = 10;
    localparam int SLOT_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int AIX_W    = 4;               // anchor index field
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 64;

    localparam logic [Q_W-1:0]     Q_MAX     = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register indexes
    localparam logic [CFG_IX_W-1:0] CFG_MASK_SETUP   = 3'd5;
    localparam logic [CFG_IX_W-1:0] CFG_GRID_SIZE    = 3'd6;
    localparam logic [CFG_IX_W-1:0] CFG_NETWORK_SIZE = 3'd7;

    localparam logic [23:0] MASK_RESET = 24'h110000;
    localparam logic [15:0] GRID_RESET = 16'h0D0D;
    localparam logic [31:0] NET_RESET  = 32'h01A0_01A0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAREA,
        ST_ANC,
        ST_DIVW,
        ST_DIVH,
        ST_INTER,
        ST_UNION,
        ST_DIVI,
        ST_PICK,
        ST_MASK,
        ST_CELL,
        ST_SLOT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TAREA,
        OP_DIV_W,
        OP_DIV_H,
        OP_INTER,
        OP_UNION,
        OP_DIV_I,
        OP_PICK,
        OP_MASK,
        OP_CELL,
        OP_SLOT,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ready;     // input side may take a word
    } cmd_t;

    typedef struct packed {
        logic div_done;  // current division result is available
        logic anc_more;  // anchors left to score
        logic uni_zero;  // union just formed is zero
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

/* src/yat_div.sv */
// ---------------------------------------------------------------------------
// yat_div - shared restoring divider
// Produces a 17-bit quotient one bit per cycle; the caller guarantees the
// quotient fits, so the upper dividend bits start as the partial remainder.
// ---------------------------------------------------------------------------
module yat_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [yat_pkg::DVD_W-1:0]   dividend,
    input  logic [yat_pkg::UNI_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [yat_pkg::Q_W-1:0]     quotient
);

    localparam int QW = yat_pkg::Q_W;
    localparam int RW = yat_pkg::UNI_W;

    logic [RW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    dvs_reg;
    logic [QW-1:0]    low_reg;
    logic [QW-1:0]    q_reg, q_next;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic [RW:0]      shifted;
    logic             ge;

    always_comb
    begin
        shifted  = {rem_reg, low_reg[QW-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? RW'(shifted - {1'b0, dvs_reg}) : RW'(shifted);
        q_next   = {q_reg[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(QW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= RW'(dividend[yat_pkg::DVD_W-1:QW]);
            low_reg <= dividend[QW-1:0];
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= q_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = q_next;

endmodule

/* src/yat_ctrl.sv */
// ---------------------------------------------------------------------------
// yat_ctrl - sequencer for the anchor target assigner
// Walks each box through truth area, per-anchor scoring, mask lookup,
// cell and slot computation, and hands the result to the output register.
// ---------------------------------------------------------------------------
module yat_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  yat_pkg::stat_t   stat,
    output yat_pkg::cmd_t    cmd
);

    yat_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= yat_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            yat_pkg::ST_IDLE:  if (in_valid) state_next = yat_pkg::ST_TAREA;
            yat_pkg::ST_TAREA: state_next = yat_pkg::ST_ANC;
            yat_pkg::ST_ANC:   state_next = stat.anc_more ? yat_pkg::ST_DIVW
                                                          : yat_pkg::ST_MASK;
            yat_pkg::ST_DIVW:  if (stat.div_done) state_next = yat_pkg::ST_DIVH;
            yat_pkg::ST_DIVH:  if (stat.div_done) state_next = yat_pkg::ST_INTER;
            yat_pkg::ST_INTER: state_next = yat_pkg::ST_UNION;
            yat_pkg::ST_UNION: state_next = stat.uni_zero ? yat_pkg::ST_PICK
                                                          : yat_pkg::ST_DIVI;
            yat_pkg::ST_DIVI:  if (stat.div_done) state_next = yat_pkg::ST_PICK;
            yat_pkg::ST_PICK:  state_next = yat_pkg::ST_ANC;
            yat_pkg::ST_MASK:  state_next = yat_pkg::ST_CELL;
            yat_pkg::ST_CELL:  state_next = yat_pkg::ST_SLOT;
            yat_pkg::ST_SLOT:  state_next = yat_pkg::ST_DONE;
            yat_pkg::ST_DONE:  if (stat.out_free) state_next = yat_pkg::ST_IDLE;
            default:           state_next = yat_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = yat_pkg::OP_NONE;
        cmd.ready = 1'b0;
        case (state_reg)
            yat_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (in_valid) cmd.op = yat_pkg::OP_LOAD;
            end
            yat_pkg::ST_TAREA: cmd.op = yat_pkg::OP_TAREA;
            yat_pkg::ST_DIVW:  cmd.op = yat_pkg::OP_DIV_W;
            yat_pkg::ST_DIVH:  cmd.op = yat_pkg::OP_DIV_H;
            yat_pkg::ST_INTER: cmd.op = yat_pkg::OP_INTER;
            yat_pkg::ST_UNION: cmd.op = yat_pkg::OP_UNION;
            yat_pkg::ST_DIVI:  cmd.op = yat_pkg::OP_DIV_I;
            yat_pkg::ST_PICK:  cmd.op = yat_pkg::OP_PICK;
            yat_pkg::ST_MASK:  cmd.op = yat_pkg::OP_MASK;
            yat_pkg::ST_CELL:  cmd.op = yat_pkg::OP_CELL;
            yat_pkg::ST_SLOT:  cmd.op = yat_pkg::OP_SLOT;
            yat_pkg::ST_DONE:  if (stat.out_free) cmd.op = yat_pkg::OP_FINISH;
            default:           cmd.op = yat_pkg::OP_NONE;
        endcase
    end

endmodule

/* src/yat_dp.sv */
// ---------------------------------------------------------------------------
// yat_dp - datapath for the anchor target assigner
// Holds configuration, the box under work, one shared 17x17 multiplier,
// the shared divider, best-anchor tracking, and the output register.
// ---------------------------------------------------------------------------
module yat_dp
#(
    parameter int MAX_ANCHORS = yat_pkg::DEF_MAX_ANCHORS,
    parameter int MAX_MASK    = yat_pkg::DEF_MAX_MASK,
    parameter int MAX_GRID    = yat_pkg::DEF_MAX_GRID
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  yat_pkg::cmd_t                 cmd,
    output yat_pkg::stat_t                stat,
    input  logic                          cfg_we,
    input  logic [yat_pkg::CFG_IX_W-1:0]  cfg_index,
    input  logic [yat_pkg::CFG_D_W-1:0]   cfg_data,
    input  logic                          in_first,
    input  logic [yat_pkg::CLASS_W-1:0]   in_class,
    input  logic [yat_pkg::Q_W-1:0]       in_x,
    input  logic [yat_pkg::Q_W-1:0]       in_y,
    input  logic [yat_pkg::Q_W-1:0]       in_w,
    input  logic [yat_pkg::Q_W-1:0]       in_h,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_written,
    output logic [yat_pkg::SLOT_W-1:0]    out_slot,
    output logic [yat_pkg::AIX_W-1:0]     out_anchor,
    output logic [yat_pkg::CLASS_W-1:0]   out_class,
    output logic [yat_pkg::Q_W-1:0]       out_x,
    output logic [yat_pkg::Q_W-1:0]       out_y,
    output logic [yat_pkg::Q_W-1:0]       out_w,
    output logic [yat_pkg::Q_W-1:0]       out_h,
    output logic [yat_pkg::COUNT_W-1:0]   out_total
);

    localparam int QW     = yat_pkg::Q_W;
    localparam int ANC_W  = $clog2(MAX_ANCHORS + 1);
    localparam int AIDX_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int MS_W   = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
    localparam int GRID_W = $clog2(MAX_GRID + 1);
    localparam int CELL_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int SUM_W  = 2 * GRID_W + MS_W + 1;

    // configuration
    logic [15:0] anc_w_reg [MAX_ANCHORS];
    logic [15:0] anc_h_reg [MAX_ANCHORS];
    logic [23:0] mask_reg;
    logic [15:0] grid_reg;
    logic [31:0] net_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ANCHORS; k++)
            begin
                anc_w_reg[k] <= '0;
                anc_h_reg[k] <= '0;
            end
            mask_reg <= yat_pkg::MASK_RESET;
            grid_reg <= yat_pkg::GRID_RESET;
            net_reg  <= yat_pkg::NET_RESET;
        end
        else if (cfg_we)
        begin
            // anchor pair registers hold entries 2i and 2i+1
            for (int k = 0; k < MAX_ANCHORS; k++)
            begin
                if (cfg_index == yat_pkg::CFG_IX_W'(k >> 1))
                begin
                    if (k % 2 == 1)
                    begin
                        anc_w_reg[k] <= cfg_data[47:32];
                        anc_h_reg[k] <= cfg_data[63:48];
                    end
                    else
                    begin
                        anc_w_reg[k] <= cfg_data[15:0];
                        anc_h_reg[k] <= cfg_data[31:16];
                    end
                end
            end
            if (cfg_index == yat_pkg::CFG_MASK_SETUP)
                mask_reg <= cfg_data[23:0];
            if (cfg_index == yat_pkg::CFG_GRID_SIZE)
                grid_reg <= cfg_data[15:0];
            if (cfg_index == yat_pkg::CFG_NETWORK_SIZE)
                net_reg <= cfg_data[31:0];
        end
    end

    // derived configuration
    logic [3:0]        n_anc;
    logic [2:0]        n_mask;
    logic [GRID_W-1:0] gw, gh;
    logic [15:0]       net_w, net_h;

    function automatic logic [GRID_W-1:0] clamp_grid(input logic [7:0] g);
        logic [GRID_W-1:0] r;
        if (g == 8'd0)
            r = GRID_W'(1);
        else if (32'(g) > MAX_GRID)
            r = GRID_W'(MAX_GRID);
        else
            r = GRID_W'(g);
        return r;
    endfunction

    always_comb
    begin
        n_anc  = (32'(mask_reg[23:20]) > MAX_ANCHORS) ? 4'(MAX_ANCHORS) : mask_reg[23:20];
        n_mask = (32'(mask_reg[18:16]) > MAX_MASK) ? 3'(MAX_MASK) : mask_reg[18:16];
        gw     = clamp_grid(grid_reg[7:0]);
        gh     = clamp_grid(grid_reg[15:8]);
        net_w  = (net_reg[15:0] == '0) ? 16'd1 : net_reg[15:0];
        net_h  = (net_reg[31:16] == '0) ? 16'd1 : net_reg[31:16];
    end

    // box under work
    logic                        first_reg;
    logic [yat_pkg::CLASS_W-1:0] class_reg;
    logic [QW-1:0]               bx_reg, by_reg, bw_reg, bh_reg;
    logic [yat_pkg::PROD_W-1:0]  ta_reg, inter_reg;
    logic [yat_pkg::UNI_W-1:0]   uni_reg, uni_next;
    logic [QW-1:0]               aw_reg, ah_reg, iou_reg, best_iou_reg;
    logic [ANC_W-1:0]            anc_reg, best_reg;
    logic                        have_best_reg;
    logic                        hit_reg;
    logic [MS_W-1:0]             mslot_reg;
    logic [CELL_W-1:0]           cx_reg, cy_reg;
    logic [2*GRID_W-1:0]         area_reg;
    logic [yat_pkg::SLOT_W-1:0]  slot_reg;
    logic [yat_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        out_valid_reg;

    // shared multiplier
    logic [QW-1:0]              mul_a, mul_b;
    logic [yat_pkg::PROD_W-1:0] prod;

    always_comb
    begin
        mul_a = aw_reg;
        mul_b = ah_reg;
        case (cmd.op)
            yat_pkg::OP_TAREA:
            begin
                mul_a = bw_reg;
                mul_b = bh_reg;
            end
            yat_pkg::OP_INTER:
            begin
                mul_a = (aw_reg < bw_reg) ? aw_reg : bw_reg;
                mul_b = (ah_reg < bh_reg) ? ah_reg : bh_reg;
            end
            default:
            begin
                mul_a = aw_reg;
                mul_b = ah_reg;
            end
        endcase
        prod     = mul_a * mul_b;
        uni_next = yat_pkg::UNI_W'(prod) + yat_pkg::UNI_W'(ta_reg)
                   - yat_pkg::UNI_W'(inter_reg);
    end

    // divider feed: anchor normalization or IoU
    logic [AIDX_W-1:0]         aidx;
    logic [15:0]               pix, net_side;
    logic                      is_norm, is_div, sat;
    logic                      div_busy, div_done, div_start, done_any;
    logic [yat_pkg::DVD_W-1:0] dvd;
    logic [yat_pkg::UNI_W-1:0] dvs;
    logic [QW-1:0]             quot;

    always_comb
    begin
        aidx     = anc_reg[AIDX_W-1:0];
        is_norm  = (cmd.op == yat_pkg::OP_DIV_W) || (cmd.op == yat_pkg::OP_DIV_H);
        is_div   = is_norm || (cmd.op == yat_pkg::OP_DIV_I);
        pix      = (cmd.op == yat_pkg::OP_DIV_H) ? anc_h_reg[aidx] : anc_w_reg[aidx];
        net_side = (cmd.op == yat_pkg::OP_DIV_H) ? net_h : net_w;
        // quotient reaches 2.0 exactly when pix >= 2 * net
        sat      = is_norm && ({1'b0, pix} >= {net_side, 1'b0});
        if (is_norm)
        begin
            dvd = yat_pkg::DVD_W'({pix, 16'd0});
            dvs = yat_pkg::UNI_W'(net_side);
        end
        else
        begin
            dvd = {inter_reg, 16'd0};
            dvs = uni_reg;
        end
        div_start = is_div && !div_busy && !sat;
        done_any  = div_done || (sat && !div_busy);
    end

    yat_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    // mask lookup: lowest matching slot wins
    logic            hit_c;
    logic [MS_W-1:0] mslot_c;

    always_comb
    begin
        hit_c   = 1'b0;
        mslot_c = '0;
        for (int j = MAX_MASK - 1; j >= 0; j--)
        begin
            if ((3'(j) < n_mask) && (mask_reg[4*j +: 4] == yat_pkg::AIX_W'(best_reg)))
            begin
                hit_c   = 1'b1;
                mslot_c = MS_W'(j);
            end
        end
    end

    // grid cell of the box center, clamped to the last cell
    logic [QW+GRID_W-1:0] pos_x, pos_y;
    logic [GRID_W:0]      cx_raw, cy_raw;
    logic [CELL_W-1:0]    cx_c, cy_c;
    logic [SUM_W-1:0]     slot_sum;

    always_comb
    begin
        pos_x  = (QW+GRID_W)'(bx_reg) * (QW+GRID_W)'(gw);
        pos_y  = (QW+GRID_W)'(by_reg) * (QW+GRID_W)'(gh);
        cx_raw = (GRID_W+1)'(pos_x >> 16);
        cy_raw = (GRID_W+1)'(pos_y >> 16);
        cx_c   = (cx_raw > (GRID_W+1)'(gw - 1'b1)) ? CELL_W'(gw - 1'b1) : CELL_W'(cx_raw);
        cy_c   = (cy_raw > (GRID_W+1)'(gh - 1'b1)) ? CELL_W'(gh - 1'b1) : CELL_W'(cy_raw);
        slot_sum = SUM_W'(mslot_reg) * SUM_W'(area_reg)
                 + SUM_W'(cy_reg) * SUM_W'(gw) + SUM_W'(cx_reg);
        count_next = (hit_reg && count_reg != yat_pkg::COUNT_MAX)
                   ? count_reg + 1'b1 : count_reg;
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == yat_pkg::OP_LOAD && in_first)
                count_reg <= '0;
            else if (cmd.op == yat_pkg::OP_FINISH)
                count_reg <= count_next;
            if (cmd.op == yat_pkg::OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            yat_pkg::OP_LOAD:
            begin
                first_reg     <= in_first;
                class_reg     <= in_class;
                bx_reg        <= in_x;
                by_reg        <= in_y;
                bw_reg        <= in_w;
                bh_reg        <= in_h;
                anc_reg       <= '0;
                best_reg      <= '0;
                have_best_reg <= 1'b0;
            end
            yat_pkg::OP_TAREA: ta_reg <= prod;
            yat_pkg::OP_DIV_W: if (done_any) aw_reg <= div_busy ? quot : yat_pkg::Q_MAX;
            yat_pkg::OP_DIV_H: if (done_any) ah_reg <= div_busy ? quot : yat_pkg::Q_MAX;
            yat_pkg::OP_INTER: inter_reg <= prod;
            yat_pkg::OP_UNION: uni_reg <= uni_next;
            yat_pkg::OP_DIV_I: if (div_done) iou_reg <= quot;
            yat_pkg::OP_PICK:
            begin
                // zero union never ranks; ties keep the earlier anchor
                if (uni_reg != '0 && (!have_best_reg || iou_reg > best_iou_reg))
                begin
                    have_best_reg <= 1'b1;
                    best_iou_reg  <= iou_reg;
                    best_reg      <= anc_reg;
                end
                anc_reg <= anc_reg + 1'b1;
            end
            yat_pkg::OP_MASK:
            begin
                hit_reg   <= hit_c;
                mslot_reg <= mslot_c;
            end
            yat_pkg::OP_CELL:
            begin
                cx_reg   <= cx_c;
                cy_reg   <= cy_c;
                area_reg <= (2*GRID_W)'(gw) * (2*GRID_W)'(gh);
            end
            yat_pkg::OP_SLOT: slot_reg <= yat_pkg::SLOT_W'(slot_sum);
            yat_pkg::OP_FINISH:
            begin
                out_written <= hit_reg;
                out_anchor  <= yat_pkg::AIX_W'(best_reg);
                out_slot    <= hit_reg ? slot_reg : '0;
                out_class   <= hit_reg ? class_reg : '0;
                out_x       <= hit_reg ? bx_reg : '0;
                out_y       <= hit_reg ? by_reg : '0;
                out_w       <= hit_reg ? bw_reg : '0;
                out_h       <= hit_reg ? bh_reg : '0;
                out_total   <= (first_reg && !hit_reg) ? '0 : count_next;
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign stat.div_done = done_any;
    assign stat.anc_more = 32'(anc_reg) < 32'(n_anc);
    assign stat.uni_zero = (uni_next == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

/* src/yolo_anchor_target_assign.sv */
// ---------------------------------------------------------------------------
// yolo_anchor_target_assign - YOLO anchor target assignment, top level
// An anchor whose side saturates skips its normalizing divide, and a zero
// union skips the IoU divide. The shared bit-serial divider sets the pace.
// One box in flight; the next box is taken while a result waits on m_tready.
// Reset: asynchronous, active low; only control, count and config registers reset.
// ---------------------------------------------------------------------------
//
// Per box the sequencer computes the truth area, then for every configured
// anchor normalizes width and height by the network size (on the divider, or
// without a divide when the side saturates at 2.0), forms the intersection
// and union on one 17x17 multiplier, divides for IoU and keeps the strictly
// better anchor. The best anchor is looked up in the layer mask, the grid
// cell is clamped, and the slot index and running count go out.
module yolo_anchor_target_assign
#(
    parameter int MAX_ANCHORS = yat_pkg::DEF_MAX_ANCHORS,
    parameter int MAX_MASK    = yat_pkg::DEF_MAX_MASK,
    parameter int MAX_GRID    = yat_pkg::DEF_MAX_GRID
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // class_id[9:0], box_x[26:10], box_y[43:27], box_w[60:44], box_h[77:61]
    input  logic [79:0]                   s_tdata,
    // first_of_image[0]
    input  logic                          s_tuser,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot[15:0], anchor_index[19:16], class_out[29:20], box_x_out[46:30],
    // box_y_out[63:47], box_w_out[80:64], box_h_out[97:81],
    // assigned_total[113:98]
    output logic [119:0]                  m_tdata,
    // written[0]
    output logic                          m_tuser,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [yat_pkg::CFG_IX_W-1:0]  cfg_index,
    input  logic [yat_pkg::CFG_D_W-1:0]   cfg_data
);

    yat_pkg::cmd_t  cmd;
    yat_pkg::stat_t stat;

    logic [yat_pkg::SLOT_W-1:0]  o_slot;
    logic [yat_pkg::AIX_W-1:0]   o_anchor;
    logic [yat_pkg::CLASS_W-1:0] o_class;
    logic [yat_pkg::Q_W-1:0]     o_x, o_y, o_w, o_h;
    logic [yat_pkg::COUNT_W-1:0] o_total;

    yat_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    yat_dp
    #(
        .MAX_ANCHORS (MAX_ANCHORS),
        .MAX_MASK    (MAX_MASK),
        .MAX_GRID    (MAX_GRID)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_first    (s_tuser),
        .in_class    (s_tdata[9:0]),
        .in_x        (s_tdata[26:10]),
        .in_y        (s_tdata[43:27]),
        .in_w        (s_tdata[60:44]),
        .in_h        (s_tdata[77:61]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_written (m_tuser),
        .out_slot    (o_slot),
        .out_anchor  (o_anchor),
        .out_class   (o_class),
        .out_x       (o_x),
        .out_y       (o_y),
        .out_w       (o_w),
        .out_h       (o_h),
        .out_total   (o_total)
    );

    // ready only in the idle state; the output register decouples the far side
    assign s_tready = cmd.ready;
    assign m_tdata  = {6'd0, o_total, o_h, o_w, o_y, o_x, o_class, o_anchor, o_slot};

endmodule
